// ===== rtl/ssbf_pkg.sv =====
`default_nettype none

package ssbf_pkg;

   // Timeline and scan geometry
   localparam int unsigned MAX_ROWS    = 65536;
   localparam int unsigned ROW_W       = $clog2(MAX_ROWS);
   localparam int unsigned CNT_W       = ROW_W + 1;
   localparam int unsigned SCAN_WINDOW = 65536;
   localparam int unsigned MAX_SOURCES = 8;
   localparam int unsigned SRC_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

   // Fixed field widths
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned MASK_W  = 8;
   localparam int unsigned PLAY_W  = 25;
   localparam int unsigned SPAN_W  = PLAY_W;
   localparam int unsigned FROW_W  = 16;
   localparam int unsigned ID_W    = 8;
   localparam int unsigned NSRC_W  = 4;
   localparam int unsigned TABLE_W = 64;
   localparam int unsigned CSR_IDX_W = 2;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FORGET = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MULTI_SOURCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_TABLE     = 2'd2;

   typedef struct packed {
      logic accept;
      logic start_query;
      logic scan_issue;
      logic latch_pending;
      logic emit_item;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic query_empty;
      logic at_stop;
      logic all_found;
      logic pending_none;
      logic pending_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/ssbf_ctrl.sv =====
`default_nettype none

module ssbf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ssbf_pkg::status_type sts,
   output ssbf_pkg::cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.is_query) begin
                  cmd.start_query = 1'b1;
                  state_in = sts.query_empty ? ST_EMIT : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // stop early once every tracked source has its row
            if (sts.all_found) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.scan_issue = 1'b1;
               if (sts.at_stop) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.latch_pending = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               if (sts.pending_none) begin
                  cmd.emit_empty = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_item = 1'b1;
                  if (sts.pending_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ssbf_datapath.sv =====
`default_nettype none

module ssbf_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ssbf_pkg::cmd_type                    cmd,
   output ssbf_pkg::status_type                      sts,
   input  wire logic [ssbf_pkg::MODE_W-1:0]          req_mode,
   input  wire logic [ssbf_pkg::MASK_W-1:0]          req_row_mask,
   input  wire logic signed [ssbf_pkg::PLAY_W-1:0]   req_playhead_row,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [ssbf_pkg::FROW_W-1:0]               rsp_found_row,
   output logic [ssbf_pkg::ID_W-1:0]                 rsp_source_id,
   output logic                                      rsp_present,
   output logic                                      rsp_last,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ssbf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ssbf_pkg::TABLE_W-1:0]         csr_wdata
);

   localparam int unsigned NS = ssbf_pkg::MAX_SOURCES;
   localparam int unsigned RW = ssbf_pkg::ROW_W;
   localparam int unsigned CW = ssbf_pkg::CNT_W;
   localparam int unsigned SW = ssbf_pkg::SPAN_W;

   // Configuration
   logic                              multi_ff;
   logic [ssbf_pkg::NSRC_W-1:0]       nsrc_ff;
   logic [ssbf_pkg::TABLE_W-1:0]      id_table_ff;

   // Timeline
   logic [ssbf_pkg::MASK_W-1:0]       mem [ssbf_pkg::MAX_ROWS];
   logic [CW-1:0]                     row_count_ff;
   logic [ssbf_pkg::MASK_W-1:0]       rd_data_ff;
   logic                              rd_valid_ff;
   logic [RW-1:0]                     rd_row_ff;

   // Scan and report state
   logic [RW-1:0]                     scan_ptr_ff;
   logic [RW-1:0]                     stop_ff;
   logic [NS-1:0]                     found_ff;
   logic [RW-1:0]                     found_row_ff [NS];
   logic [NS-1:0]                     lr_valid_ff;
   logic [RW-1:0]                     lr_row_ff [NS];
   logic [NS-1:0]                     pending_ff;

   // Result register
   logic                              rsp_valid_ff;
   logic [ssbf_pkg::FROW_W-1:0]       rsp_row_ff;
   logic [ssbf_pkg::ID_W-1:0]         rsp_id_ff;
   logic                              rsp_present_ff;
   logic                              rsp_last_ff;

   logic [ssbf_pkg::NSRC_W-1:0]       nsrc_eff;
   logic [NS-1:0]                     tracked;
   logic [NS-1:0]                     same_row;
   logic [CW-1:0]                     last_row;
   logic [SW-1:0]                     play_ext;
   logic [SW-1:0]                     last_ext;
   logic [SW-1:0]                     top_ext;
   logic [SW-1:0]                     stop_ext;
   logic [ssbf_pkg::SRC_W-1:0]        sel;
   logic [NS-1:0]                     sel_onehot;
   logic                              out_free;
   logic                              full;

   assign csr_ready = 1'b1;
   assign full      = (row_count_ff >= CW'(ssbf_pkg::MAX_ROWS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      nsrc_eff = (nsrc_ff > ssbf_pkg::NSRC_W'(NS)) ? ssbf_pkg::NSRC_W'(NS) : nsrc_ff;
      for (int b = 0; b < NS; b++) begin
         tracked[b]  = (ssbf_pkg::NSRC_W'(b) < nsrc_eff);
         same_row[b] = lr_valid_ff[b] && (lr_row_ff[b] == found_row_ff[b]);
      end
   end

   // Scan bounds: start at the smaller of playhead and newest row
   always_comb begin
      last_row = row_count_ff - CW'(1);
      play_ext = {1'b0, req_playhead_row[ssbf_pkg::PLAY_W-2:0]};
      last_ext = SW'(last_row);
      top_ext  = (play_ext < last_ext) ? play_ext : last_ext;
      stop_ext = (top_ext >= SW'(ssbf_pkg::SCAN_WINDOW))
                 ? (top_ext - SW'(ssbf_pkg::SCAN_WINDOW)) : '0;
   end

   // Lowest pending source goes out first
   always_comb begin
      sel = '0;
      for (int b = NS - 1; b >= 0; b--) begin
         if (pending_ff[b]) begin
            sel = ssbf_pkg::SRC_W'(b);
         end
      end
      sel_onehot = NS'(1) << sel;
   end

   always_comb begin
      sts.is_query     = (req_mode == ssbf_pkg::MODE_QUERY);
      sts.query_empty  = !multi_ff || (nsrc_eff == '0)
                         || req_playhead_row[ssbf_pkg::PLAY_W-1] || (row_count_ff == '0);
      sts.at_stop      = (scan_ptr_ff == stop_ff);
      sts.all_found    = ((found_ff | ~tracked) == '1);
      sts.pending_none = (pending_ff == '0);
      sts.pending_last = ((pending_ff & ~sel_onehot) == '0);
      sts.out_free     = out_free;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         multi_ff    <= 1'b0;
         nsrc_ff     <= '0;
         id_table_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ssbf_pkg::CSR_MULTI_SOURCE: multi_ff    <= csr_wdata[0];
            ssbf_pkg::CSR_SOURCE_COUNT: nsrc_ff     <= csr_wdata[ssbf_pkg::NSRC_W-1:0];
            ssbf_pkg::CSR_ID_TABLE:     id_table_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Timeline memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_mode == ssbf_pkg::MODE_APPEND) && !full) begin
         mem[row_count_ff[RW-1:0]] <= req_row_mask;
      end
      rd_data_ff <= mem[scan_ptr_ff];
      rd_row_ff  <= scan_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_issue;
         if (cmd.accept) begin
            if (req_mode == ssbf_pkg::MODE_APPEND && !full) begin
               row_count_ff <= row_count_ff + CW'(1);
            end else if (req_mode == ssbf_pkg::MODE_CLEAR) begin
               row_count_ff <= '0;
            end
         end
      end
   end

   // Scan pointer walks backward toward the stop row
   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         scan_ptr_ff <= top_ext[RW-1:0];
         stop_ff     <= stop_ext[RW-1:0];
      end else if (cmd.scan_issue && (scan_ptr_ff != stop_ff)) begin
         scan_ptr_ff <= scan_ptr_ff - RW'(1);
      end
   end

   // Latch the first hit per source; later reads never overwrite it
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= '0;
      end else if (cmd.start_query) begin
         found_ff <= '0;
      end else if (rd_valid_ff) begin
         for (int b = 0; b < NS; b++) begin
            if (tracked[b] && !found_ff[b] && rd_data_ff[b]) begin
               found_ff[b] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         for (int b = 0; b < NS; b++) begin
            if (tracked[b] && !found_ff[b] && rd_data_ff[b]) begin
               found_row_ff[b] <= rd_row_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (cmd.start_query) begin
         pending_ff <= '0;
      end else if (cmd.latch_pending) begin
         pending_ff <= tracked & found_ff & ~same_row;
      end else if (cmd.emit_item) begin
         pending_ff <= pending_ff & ~sel_onehot;
      end
   end

   // Last reported rows; forget on a forget or clear request
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_valid_ff <= '0;
      end else if (cmd.accept && (req_mode == ssbf_pkg::MODE_FORGET
                                  || req_mode == ssbf_pkg::MODE_CLEAR)) begin
         lr_valid_ff <= '0;
      end else if (cmd.emit_item) begin
         lr_valid_ff <= lr_valid_ff | sel_onehot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_item) begin
         lr_row_ff[sel] <= found_row_ff[sel];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_item || cmd.emit_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_item) begin
         rsp_row_ff     <= ssbf_pkg::FROW_W'(found_row_ff[sel]);
         rsp_id_ff      <= id_table_ff[sel * ssbf_pkg::ID_W +: ssbf_pkg::ID_W];
         rsp_present_ff <= 1'b1;
         rsp_last_ff    <= sts.pending_last;
      end else if (cmd.emit_empty) begin
         rsp_row_ff     <= '0;
         rsp_id_ff      <= '0;
         rsp_present_ff <= 1'b0;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found_row = rsp_row_ff;
   assign rsp_source_id = rsp_id_ff;
   assign rsp_present   = rsp_present_ff;
   assign rsp_last      = rsp_last_ff;

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_item || cmd.emit_empty) |-> out_free)
      else $error("result written while result register still held");

   a_emit_has_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_item |-> (pending_ff != '0))
      else $error("item emitted with no pending source");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> (scan_ptr_ff >= stop_ff))
      else $error("scan pointer passed the stop row");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= CW'(ssbf_pkg::MAX_ROWS))
      else $error("row count beyond capacity");

   a_reported_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_item |=> ((lr_valid_ff & $past(sel_onehot)) != '0))
      else $error("emitted source not recorded as reported");

endmodule

`default_nettype wire

// ===== rtl/sparse_source_backfill_finder.sv =====
// Sparse source backfill finder.
// Request channel (req_valid/req_stall): req_mode selects append of req_row_mask,
// query at req_playhead_row, forget of the last reported rows, or timeline clear.
// Result channel (rsp_valid/rsp_stall): a query returns one or more results, one
// per source whose latest row at or before the playhead changed since it was last
// reported, in source order, or a single empty result (rsp_present low); rsp_last
// marks the final result. Other modes return nothing.
// Append, forget and clear finish on accept. A query walks the timeline memory
// backward one row per cycle through its single read port: up to min(playhead,
// newest row) + 1 rows, bounded by the scan window, or up to one row past the row
// that completes the set of tracked sources; it then latches the pending sources
// (after a drain state if the scan reached the stop row) and loads its results
// into the result register in turn. An empty answer goes to emission straight
// from accept. Only one request is in flight; req_stall stays high from query
// accept until its last result is loaded into the result register. A stalled
// receiver holds the result register and freezes result emission. Registers are
// written on csr_valid (csr_ready is always high); the user must write them only
// while idle, which the block does not enforce. Reset empties the timeline,
// forgets reported rows and clears the registers; no clearing pass is needed.
`default_nettype none

module sparse_source_backfill_finder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [ssbf_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [ssbf_pkg::MASK_W-1:0]         req_row_mask,
   input  wire logic signed [ssbf_pkg::PLAY_W-1:0]  req_playhead_row,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ssbf_pkg::FROW_W-1:0]              rsp_found_row,
   output logic [ssbf_pkg::ID_W-1:0]                rsp_source_id,
   output logic                                     rsp_present,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ssbf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ssbf_pkg::TABLE_W-1:0]        csr_wdata
);

   ssbf_pkg::cmd_type    cmd;
   ssbf_pkg::status_type sts;

   ssbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ssbf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_row_mask     (req_row_mask),
      .req_playhead_row (req_playhead_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found_row    (rsp_found_row),
      .rsp_source_id    (rsp_source_id),
      .rsp_present      (rsp_present),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

`default_nettype wire
